// ===== rtl/aisg_pkg.sv =====
package aisg_pkg;

  localparam int COUNT_BITS   = 24;
  localparam int TRAFFIC_BITS = 40;
  localparam int LEVEL_BITS   = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = TRAFFIC_BITS;

  localparam logic [COUNT_BITS-1:0]   COUNT_MAX   = {COUNT_BITS{1'b1}};
  localparam logic [TRAFFIC_BITS-1:0] TRAFFIC_MAX = {TRAFFIC_BITS{1'b1}};
  localparam logic [LEVEL_BITS-1:0]   LEVEL_MAX   = {LEVEL_BITS{1'b1}};

  // Request commands
  localparam logic [2:0] CMD_SAMPLE     = 3'd0;
  localparam logic [2:0] CMD_TICK_END   = 3'd1;
  localparam logic [2:0] CMD_SUSPEND    = 3'd2;
  localparam logic [2:0] CMD_RESUME     = 3'd3;
  localparam logic [2:0] CMD_SET_ENABLE = 3'd4;
  localparam logic [2:0] CMD_SET_SLEEP  = 3'd5;
  localparam logic [2:0] CMD_END_QUERY  = 3'd6;
  localparam logic [2:0] CMD_RELEASE    = 3'd7;

  // Sample sources
  localparam logic [1:0] CH_CPU     = 2'd0;
  localparam logic [1:0] CH_DISK    = 2'd1;
  localparam logic [1:0] CH_TRAFFIC = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_MONITOR_MASK   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CPU_BUSY       = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DISK_BUSY      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TRAFFIC_BUSY   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_CPU_QUIET      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DISK_QUIET     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_TRAFFIC_QUIET  = 3'd6;

  typedef struct packed {
    logic [2:0]              cmd;
    logic [1:0]              channel;
    logic [TRAFFIC_BITS-1:0] sample_value;
    logic                    flag;
  } in_req_t;

  typedef struct packed {
    logic blocking;
    logic enabled;
    logic sleep_armed;
    logic enter_sleep;
    logic end_session_allowed;
  } out_req_t;

  // Clear on busy, else count up and hold at full scale
  function automatic logic [COUNT_BITS-1:0] quiet_update(
    input logic [COUNT_BITS-1:0] count,
    input logic                  busy
  );
    logic [COUNT_BITS-1:0] res;
    if (busy) begin
      res = '0;
    end else if (count == COUNT_MAX) begin
      res = COUNT_MAX;
    end else begin
      res = count + 1'b1;
    end
    return res;
  endfunction

endpackage

// ===== rtl/activity_idle_shutdown_guard.sv =====
// Activity idle shutdown guard. Each request (sample, tick end, suspend, resume,
// set enable, set sleep, end query, forced release) is taken and its status word
// appears in the output register on the next cycle; a new request can be taken
// every cycle as long as the output register is empty or being drained, so the
// sustained rate is one request per clock. The rate is set by the single state
// update path: one 40-bit saturating add for traffic, or on a tick end a 24-bit
// counter step followed by its compare against the quiet threshold. The user
// must write configuration registers through the write port only while no
// request is in flight; the block does not enforce this. No read-back, no clearing pass.
module activity_idle_shutdown_guard (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  aisg_pkg::in_req_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output aisg_pkg::out_req_t                  out_data,
  input  logic                                cfg_write_en,
  input  logic [aisg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [aisg_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import aisg_pkg::*;

  // Configuration
  logic [2:0]              monitor_mask;
  logic [LEVEL_BITS-1:0]   cpu_busy_level;
  logic [LEVEL_BITS-1:0]   disk_busy_level;
  logic [TRAFFIC_BITS-1:0] traffic_busy_level;
  logic [COUNT_BITS-1:0]   cpu_quiet_needed;
  logic [COUNT_BITS-1:0]   disk_quiet_needed;
  logic [COUNT_BITS-1:0]   traffic_quiet_needed;

  // State
  logic [COUNT_BITS-1:0]   cpu_quiet_count, cpu_quiet_count_next;
  logic [COUNT_BITS-1:0]   disk_quiet_count, disk_quiet_count_next;
  logic [COUNT_BITS-1:0]   traffic_quiet_count, traffic_quiet_count_next;
  logic [LEVEL_BITS-1:0]   cpu_peak, cpu_peak_next;
  logic [LEVEL_BITS-1:0]   disk_peak, disk_peak_next;
  logic [TRAFFIC_BITS-1:0] traffic_total, traffic_total_next;
  logic [2:0]              sample_seen, sample_seen_next;
  logic                    blocking_flag, blocking_flag_next;
  logic                    enabled_flag, enabled_flag_next;
  logic                    chosen_enable, chosen_enable_next;
  logic                    sleep_flag, sleep_flag_next;

  logic                    in_accept;
  logic [LEVEL_BITS-1:0]   level_sample;
  logic [TRAFFIC_BITS:0]   traffic_sum;
  logic                    quiet_short;
  out_req_t                result;

  // Take a request whenever the output register is free or draining
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // Clip cpu/disk sample to the level range
  assign level_sample = (|in_data.sample_value[TRAFFIC_BITS-1:LEVEL_BITS]) ?
                        LEVEL_MAX : in_data.sample_value[LEVEL_BITS-1:0];
  assign traffic_sum  = {1'b0, traffic_total} + {1'b0, in_data.sample_value};

  // Compute next state and status for the request
  always_comb begin
    cpu_quiet_count_next     = cpu_quiet_count;
    disk_quiet_count_next    = disk_quiet_count;
    traffic_quiet_count_next = traffic_quiet_count;
    cpu_peak_next            = cpu_peak;
    disk_peak_next           = disk_peak;
    traffic_total_next       = traffic_total;
    sample_seen_next         = sample_seen;
    blocking_flag_next       = blocking_flag;
    enabled_flag_next        = enabled_flag;
    chosen_enable_next       = chosen_enable;
    sleep_flag_next          = sleep_flag;
    quiet_short              = 1'b0;
    result.enter_sleep         = 1'b0;
    result.end_session_allowed = 1'b1;

    case (in_data.cmd)
      CMD_SAMPLE: begin
        case (in_data.channel)
          CH_CPU: begin
            if (level_sample > cpu_peak) begin
              cpu_peak_next = level_sample;
            end
            sample_seen_next[0] = 1'b1;
          end
          CH_DISK: begin
            if (level_sample > disk_peak) begin
              disk_peak_next = level_sample;
            end
            sample_seen_next[1] = 1'b1;
          end
          CH_TRAFFIC: begin
            traffic_total_next  = traffic_sum[TRAFFIC_BITS] ? TRAFFIC_MAX :
                                  traffic_sum[TRAFFIC_BITS-1:0];
            sample_seen_next[2] = 1'b1;
          end
          default: begin
            // unknown source: drop the sample
          end
        endcase
      end
      CMD_TICK_END: begin
        if (sample_seen[0]) begin
          cpu_quiet_count_next = quiet_update(cpu_quiet_count, cpu_peak > cpu_busy_level);
        end
        if (sample_seen[1]) begin
          disk_quiet_count_next = quiet_update(disk_quiet_count,
                                               disk_peak > disk_busy_level);
        end
        if (sample_seen[2]) begin
          traffic_quiet_count_next = quiet_update(traffic_quiet_count,
                                                  traffic_total > traffic_busy_level);
        end
        cpu_peak_next      = '0;
        disk_peak_next     = '0;
        traffic_total_next = '0;
        sample_seen_next   = '0;
        // Blocking check against the counters as they stand after this tick
        quiet_short =
          (monitor_mask[0] && (cpu_quiet_count_next < cpu_quiet_needed)) ||
          (monitor_mask[1] && (disk_quiet_count_next < disk_quiet_needed)) ||
          (monitor_mask[2] && (traffic_quiet_count_next < traffic_quiet_needed));
        if (enabled_flag) begin
          if (blocking_flag && !quiet_short) begin
            blocking_flag_next = 1'b0;
            if (sleep_flag) begin
              sleep_flag_next    = 1'b0;
              result.enter_sleep = 1'b1;
            end
          end else if (!blocking_flag && quiet_short) begin
            blocking_flag_next = 1'b1;
          end
        end
      end
      CMD_SUSPEND: begin
        enabled_flag_next = 1'b0;
      end
      CMD_RESUME: begin
        enabled_flag_next = chosen_enable;
      end
      CMD_SET_ENABLE: begin
        enabled_flag_next  = in_data.flag;
        chosen_enable_next = in_data.flag;
        if (in_data.flag) begin
          blocking_flag_next = 1'b0;
        end
      end
      CMD_SET_SLEEP: begin
        sleep_flag_next = in_data.flag;
      end
      CMD_END_QUERY: begin
        if (enabled_flag && blocking_flag) begin
          sleep_flag_next            = 1'b0;
          result.end_session_allowed = 1'b0;
        end
      end
      CMD_RELEASE: begin
        blocking_flag_next = 1'b0;
      end
      default: begin
        blocking_flag_next = blocking_flag;
      end
    endcase

    result.blocking    = blocking_flag_next;
    result.enabled     = enabled_flag_next;
    result.sleep_armed = sleep_flag_next;
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      monitor_mask         <= '0;
      cpu_busy_level       <= '0;
      disk_busy_level      <= '0;
      traffic_busy_level   <= '0;
      cpu_quiet_needed     <= '0;
      disk_quiet_needed    <= '0;
      traffic_quiet_needed <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_MONITOR_MASK:  monitor_mask         <= cfg_data[2:0];
        REG_CPU_BUSY:      cpu_busy_level       <= cfg_data[LEVEL_BITS-1:0];
        REG_DISK_BUSY:     disk_busy_level      <= cfg_data[LEVEL_BITS-1:0];
        REG_TRAFFIC_BUSY:  traffic_busy_level   <= cfg_data[TRAFFIC_BITS-1:0];
        REG_CPU_QUIET:     cpu_quiet_needed     <= cfg_data[COUNT_BITS-1:0];
        REG_DISK_QUIET:    disk_quiet_needed    <= cfg_data[COUNT_BITS-1:0];
        REG_TRAFFIC_QUIET: traffic_quiet_needed <= cfg_data[COUNT_BITS-1:0];
        default: begin
          // no register at this index: drop the write
        end
      endcase
    end
  end

  // Advance state on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_quiet_count     <= '0;
      disk_quiet_count    <= '0;
      traffic_quiet_count <= '0;
      cpu_peak            <= '0;
      disk_peak           <= '0;
      traffic_total       <= '0;
      sample_seen         <= '0;
      blocking_flag       <= 1'b0;
      enabled_flag        <= 1'b0;
      chosen_enable       <= 1'b0;
      sleep_flag          <= 1'b0;
    end else if (in_accept) begin
      cpu_quiet_count     <= cpu_quiet_count_next;
      disk_quiet_count    <= disk_quiet_count_next;
      traffic_quiet_count <= traffic_quiet_count_next;
      cpu_peak            <= cpu_peak_next;
      disk_peak           <= disk_peak_next;
      traffic_total       <= traffic_total_next;
      sample_seen         <= sample_seen_next;
      blocking_flag       <= blocking_flag_next;
      enabled_flag        <= enabled_flag_next;
      chosen_enable       <= chosen_enable_next;
      sleep_flag          <= sleep_flag_next;
    end
  end

  // Output register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= result;
    end
  end

  // A sleep pulse always comes with the block released and sleep disarmed
  a_sleep_pulse: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.enter_sleep |-> !out_data.blocking && !out_data.sleep_armed)
    else $error("enter_sleep with blocking or sleep still armed");

  // A denied end query only happens while enabled and blocking, with sleep dropped
  a_deny: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.end_session_allowed |->
      out_data.blocking && out_data.enabled && !out_data.sleep_armed)
    else $error("end query denied outside an enabled block");

  // Every accepted request shows a status word on the next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted request produced no status");

  // A tick end clears the per-tick accumulators
  a_tick_clear: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_data.cmd == CMD_TICK_END |=>
      sample_seen == '0 && traffic_total == '0 && cpu_peak == '0 && disk_peak == '0)
    else $error("tick end left accumulators set");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import aisg_pkg::*;

  localparam int ITEMS_PER_PHASE = 230;
  localparam int PHASES = 6;
  localparam int LONG_HOLD = 150;
  localparam int MAX_REPORTS = 100;
  localparam longint LIMIT_NS = 5_000_000;
  // Register slot that holds nothing; writes to it must be ignored
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
  // Sample source that the block ignores
  localparam logic [1:0] CH_NONE = 2'd3;

  typedef struct {
    in_req_t  req;
    bit       known;
    out_req_t want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_req_t out_data;
  logic cfg_write_en = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Guard settings as last written
  logic [2:0]              mon_mask  = '0;
  logic [LEVEL_BITS-1:0]   lvl_cpu   = '0;
  logic [LEVEL_BITS-1:0]   lvl_disk  = '0;
  logic [TRAFFIC_BITS-1:0] lvl_net   = '0;
  logic [COUNT_BITS-1:0]   need_cpu  = '0;
  logic [COUNT_BITS-1:0]   need_disk = '0;
  logic [COUNT_BITS-1:0]   need_net  = '0;

  // Predicted guard state
  logic [COUNT_BITS-1:0]   q_cpu     = '0;
  logic [COUNT_BITS-1:0]   q_disk    = '0;
  logic [COUNT_BITS-1:0]   q_net     = '0;
  logic [LEVEL_BITS-1:0]   pk_cpu    = '0;
  logic [LEVEL_BITS-1:0]   pk_disk   = '0;
  logic [TRAFFIC_BITS-1:0] net_sum   = '0;
  logic [2:0]              seen      = '0;
  logic                    blk       = 1'b0;
  logic                    en        = 1'b0;
  logic                    en_choice = 1'b0;
  logic                    sleep_req = 1'b0;

  logic [CFG_DATA_BITS-1:0] cfg_vals [0:7];
  out_req_t    status_q [$];
  script_row_t script_q [$];
  bit offering = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_gen = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int fail_count = 0;

  activity_idle_shutdown_guard uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Clear on busy, else count up and hold at full scale
  function automatic logic [COUNT_BITS-1:0] step_quiet(input logic [COUNT_BITS-1:0] n,
                                                      input logic busy);
    if (busy) return '0;
    if (&n) return n;
    return n + 1'b1;
  endfunction

  function automatic void store_setting(input logic [CFG_IDX_BITS-1:0] idx,
                                        input logic [CFG_DATA_BITS-1:0] d);
    case (idx)
      REG_MONITOR_MASK:  mon_mask  = d[2:0];
      REG_CPU_BUSY:      lvl_cpu   = d[LEVEL_BITS-1:0];
      REG_DISK_BUSY:     lvl_disk  = d[LEVEL_BITS-1:0];
      REG_TRAFFIC_BUSY:  lvl_net   = d[TRAFFIC_BITS-1:0];
      REG_CPU_QUIET:     need_cpu  = d[COUNT_BITS-1:0];
      REG_DISK_QUIET:    need_disk = d[COUNT_BITS-1:0];
      REG_TRAFFIC_QUIET: need_net  = d[COUNT_BITS-1:0];
      default: ;
    endcase
  endfunction

  // Advance the guard by one request and return its status word
  function automatic out_req_t next_status(input in_req_t r);
    out_req_t s;
    logic [LEVEL_BITS-1:0] clipped;
    logic [TRAFFIC_BITS:0] sum;
    logic hold_back;
    s.enter_sleep = 1'b0;
    s.end_session_allowed = 1'b1;
    clipped = ((r.sample_value >> LEVEL_BITS) != 0) ? LEVEL_MAX
                                                    : r.sample_value[LEVEL_BITS-1:0];
    case (r.cmd)
      CMD_SAMPLE: begin
        if (r.channel == CH_CPU) begin
          if (clipped > pk_cpu) pk_cpu = clipped;
          seen[0] = 1'b1;
        end else if (r.channel == CH_DISK) begin
          if (clipped > pk_disk) pk_disk = clipped;
          seen[1] = 1'b1;
        end else if (r.channel == CH_TRAFFIC) begin
          sum = {1'b0, net_sum} + {1'b0, r.sample_value};
          net_sum = sum[TRAFFIC_BITS] ? TRAFFIC_MAX : sum[TRAFFIC_BITS-1:0];
          seen[2] = 1'b1;
        end
      end
      CMD_TICK_END: begin
        if (seen[0]) q_cpu  = step_quiet(q_cpu, pk_cpu > lvl_cpu);
        if (seen[1]) q_disk = step_quiet(q_disk, pk_disk > lvl_disk);
        if (seen[2]) q_net  = step_quiet(q_net, net_sum > lvl_net);
        pk_cpu  = '0;
        pk_disk = '0;
        net_sum = '0;
        seen    = '0;
        if (en) begin
          hold_back = (mon_mask[0] && q_cpu < need_cpu) ||
                      (mon_mask[1] && q_disk < need_disk) ||
                      (mon_mask[2] && q_net < need_net);
          if (blk && !hold_back) begin
            blk = 1'b0;
            if (sleep_req) begin
              sleep_req = 1'b0;
              s.enter_sleep = 1'b1;
            end
          end else if (!blk && hold_back) begin
            blk = 1'b1;
          end
        end
      end
      CMD_SUSPEND: en = 1'b0;
      CMD_RESUME:  en = en_choice;
      CMD_SET_ENABLE: begin
        en = r.flag;
        en_choice = r.flag;
        if (r.flag) blk = 1'b0;
      end
      CMD_SET_SLEEP: sleep_req = r.flag;
      CMD_END_QUERY: begin
        if (en && blk) begin
          sleep_req = 1'b0;
          s.end_session_allowed = 1'b0;
        end
      end
      default: blk = 1'b0;
    endcase
    s.blocking = blk;
    s.enabled = en;
    s.sleep_armed = sleep_req;
    return s;
  endfunction

  function automatic in_req_t mk_req(input logic [2:0] cmd, input logic [1:0] ch,
                                     input logic [TRAFFIC_BITS-1:0] v, input logic f);
    in_req_t r;
    r.cmd = cmd;
    r.channel = ch;
    r.sample_value = v;
    r.flag = f;
    return r;
  endfunction

  function automatic out_req_t mk_stat(input logic b, input logic e, input logic s,
                                       input logic p, input logic a);
    out_req_t o;
    o.blocking = b;
    o.enabled = e;
    o.sleep_armed = s;
    o.enter_sleep = p;
    o.end_session_allowed = a;
    return o;
  endfunction

  function automatic void add_row(input in_req_t r, input bit known, input out_req_t w);
    script_row_t row;
    row.req = r;
    row.known = known;
    row.want = w;
    script_q.push_back(row);
  endfunction

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $error("%s: expected %0b, actual %0b", name, want, got);
    end
  endtask

  // Offer one request, hold it until taken, then record its expected status
  task automatic issue(input in_req_t r, input bit known, input out_req_t want);
    int gap;
    out_req_t predicted;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      if (offering) in_valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    offering = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = next_status(r);
    status_q.push_back(known ? want : predicted);
  endtask

  // Drop valid and wait until every status word is back
  task automatic settle();
    if (offering) in_valid <= 1'b0;
    offering = 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write every register slot in turn, including the unused one
  task automatic write_settings();
    for (int i = 0; i <= int'(REG_UNUSED); i++) begin
      cfg_write_en <= 1'b1;
      cfg_index <= CFG_IDX_BITS'(i);
      cfg_data <= cfg_vals[i];
      @(posedge clk);
      store_setting(CFG_IDX_BITS'(i), cfg_vals[i]);
    end
    cfg_write_en <= 1'b0;
  endtask

  // Take status words, compare, and pick the next stall
  always @(posedge clk) begin
    out_req_t want;
    if (!rst && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $error("status word %b with no request pending", out_data);
      end else begin
        want = status_q.pop_front();
        check_field("blocking", want.blocking, out_data.blocking);
        check_field("enabled", want.enabled, out_data.enabled);
        check_field("sleep_armed", want.sleep_armed, out_data.sleep_armed);
        check_field("enter_sleep", want.enter_sleep, out_data.enter_sleep);
        check_field("end_session_allowed", want.end_session_allowed,
                    out_data.end_session_allowed);
      end
    end
    if (hold_seen != hold_gen) begin
      hold_seen = hold_gen;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    in_req_t r;
    int sel;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Settings for the directed part
    cfg_vals[REG_MONITOR_MASK]  = 40'd7;
    cfg_vals[REG_CPU_BUSY]      = 40'd1000;
    cfg_vals[REG_DISK_BUSY]     = 40'd1000;
    cfg_vals[REG_TRAFFIC_BUSY]  = 40'd1_000_000;
    cfg_vals[REG_CPU_QUIET]     = 40'd2;
    cfg_vals[REG_DISK_QUIET]    = 40'd2;
    cfg_vals[REG_TRAFFIC_QUIET] = 40'd2;
    cfg_vals[REG_UNUSED]        = '1;
    write_settings();

    // Directed requests; status typed in where it is obvious
    add_row(mk_req(CMD_END_QUERY, CH_CPU, '0, 1'b0), 1, mk_stat(0, 0, 0, 0, 1));
    add_row(mk_req(CMD_SET_SLEEP, CH_CPU, '0, 1'b1), 1, mk_stat(0, 0, 1, 0, 1));
    add_row(mk_req(CMD_SET_ENABLE, CH_CPU, '0, 1'b1), 1, mk_stat(0, 1, 1, 0, 1));
    add_row(mk_req(CMD_SAMPLE, CH_CPU, '1, 1'b0), 1, mk_stat(0, 1, 1, 0, 1));
    add_row(mk_req(CMD_SAMPLE, CH_DISK, '0, 1'b1), 1, mk_stat(0, 1, 1, 0, 1));
    add_row(mk_req(CMD_SAMPLE, CH_TRAFFIC, '1, 1'b0), 1, mk_stat(0, 1, 1, 0, 1));
    add_row(mk_req(CMD_SAMPLE, CH_TRAFFIC, 40'd1, 1'b0), 1, mk_stat(0, 1, 1, 0, 1));
    add_row(mk_req(CMD_SAMPLE, CH_NONE, 40'h12345, 1'b1), 1, mk_stat(0, 1, 1, 0, 1));
    add_row(mk_req(CMD_TICK_END, CH_CPU, '0, 1'b0), 1, mk_stat(1, 1, 1, 0, 1));
    add_row(mk_req(CMD_END_QUERY, CH_CPU, '0, 1'b0), 1, mk_stat(1, 1, 0, 0, 0));
    add_row(mk_req(CMD_SET_SLEEP, CH_CPU, '0, 1'b1), 1, mk_stat(1, 1, 1, 0, 1));
    add_row(mk_req(CMD_SAMPLE, CH_CPU, 40'd1000, 1'b0), 0, '0);
    add_row(mk_req(CMD_SAMPLE, CH_DISK, 40'd65536, 1'b0), 0, '0);
    add_row(mk_req(CMD_SAMPLE, CH_TRAFFIC, 40'd1_000_000, 1'b0), 0, '0);
    add_row(mk_req(CMD_TICK_END, CH_CPU, '0, 1'b0), 0, '0);
    add_row(mk_req(CMD_TICK_END, CH_DISK, '0, 1'b1), 0, '0);
    add_row(mk_req(CMD_SAMPLE, CH_CPU, '0, 1'b0), 0, '0);
    add_row(mk_req(CMD_SAMPLE, CH_DISK, 40'd5, 1'b0), 0, '0);
    add_row(mk_req(CMD_SAMPLE, CH_TRAFFIC, '0, 1'b0), 0, '0);
    add_row(mk_req(CMD_TICK_END, CH_CPU, '0, 1'b0), 0, '0);
    add_row(mk_req(CMD_SAMPLE, CH_DISK, '0, 1'b0), 0, '0);
    add_row(mk_req(CMD_TICK_END, CH_CPU, '0, 1'b0), 0, '0);
    add_row(mk_req(CMD_SUSPEND, CH_CPU, '0, 1'b0), 1, mk_stat(0, 0, 0, 0, 1));
    add_row(mk_req(CMD_END_QUERY, CH_CPU, '0, 1'b0), 1, mk_stat(0, 0, 0, 0, 1));
    add_row(mk_req(CMD_RESUME, CH_CPU, '0, 1'b0), 1, mk_stat(0, 1, 0, 0, 1));
    add_row(mk_req(CMD_SET_ENABLE, CH_CPU, '0, 1'b0), 1, mk_stat(0, 0, 0, 0, 1));
    add_row(mk_req(CMD_RESUME, CH_CPU, '0, 1'b0), 1, mk_stat(0, 0, 0, 0, 1));
    add_row(mk_req(CMD_SAMPLE, CH_CPU, 40'd65535, 1'b0), 0, '0);
    add_row(mk_req(CMD_TICK_END, CH_CPU, '0, 1'b0), 0, '0);
    add_row(mk_req(CMD_SET_ENABLE, CH_CPU, '0, 1'b1), 0, '0);
    add_row(mk_req(CMD_RELEASE, CH_NONE, '1, 1'b1), 1, mk_stat(0, 1, 0, 0, 1));

    send_idle_pct = 30;
    recv_stall_pct = 64;
    foreach (script_q[k]) issue(script_q[k].req, script_q[k].known, script_q[k].want);

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      // Extremes first, then random settings with short quiet requirements
      for (int i = 0; i <= int'(REG_UNUSED); i++) begin
        if (phase == 0) cfg_vals[i] = '1;
        else if (phase == 1) cfg_vals[i] = '0;
        else cfg_vals[i] = {8'($urandom), 32'($urandom)};
      end
      if (phase > 1) begin
        cfg_vals[REG_CPU_QUIET]     = {16'($urandom), 24'($urandom_range(5))};
        cfg_vals[REG_DISK_QUIET]    = {16'($urandom), 24'($urandom_range(5))};
        cfg_vals[REG_TRAFFIC_QUIET] = {16'($urandom), 24'($urandom_range(5))};
      end
      write_settings();

      if (phase < 2) begin
        send_idle_pct = 30;
        recv_stall_pct = 64;
      end else if (phase < 4) begin
        send_idle_pct = 64;
        recv_stall_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Hold off the receiver for a long stretch while requests keep coming
        if (n == 100) hold_gen++;
        r.cmd = CMD_SAMPLE;
        r.channel = 2'($urandom_range(3));
        r.sample_value = {8'($urandom), 32'($urandom)};
        r.flag = 1'($urandom);
        sel = $urandom_range(99);
        // Mostly ticks made of samples and a tick end, with other commands mixed in
        if (sel < 68) begin
          r.channel = ($urandom_range(19) == 0) ? CH_NONE : 2'($urandom_range(2));
          case ($urandom_range(9))
            0, 1, 2, 3, 4: r.sample_value = TRAFFIC_BITS'($urandom_range(400));
            5, 6:          r.sample_value = TRAFFIC_BITS'($urandom_range(65535));
            7:             ;
            8:             r.sample_value = '1;
            default:       r.sample_value = '0;
          endcase
        end else if (sel < 84) begin
          r.cmd = CMD_TICK_END;
        end else if (sel < 90) begin
          r.cmd = CMD_SET_ENABLE;
          r.flag = ($urandom_range(3) != 0);
        end else begin
          r.cmd = 3'($urandom_range(CMD_SUSPEND, CMD_RELEASE));
        end
        issue(r, 0, '0);
      end
    end

    settle();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/aisg_pkg.sv
rtl/activity_idle_shutdown_guard.sv
tb/sv/testbench.sv
